[src/falc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package falc_pkg;

    localparam int NUM_LINES_DEF  = 8;
    localparam int LINE_BYTES_DEF = 32;
    localparam int ADDR_BITS_DEF  = 32;

    localparam int ADDR_W     = 32;
    localparam int LINE_OUT_W = 3;
    localparam int CNT_W      = 32;
    localparam int STAMP_W    = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SEARCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic reduce;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic resolved;
    } t_status;

endpackage

`default_nettype wire

[src/falc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface falc_req_if;
    logic                          valid;
    logic                          ready;
    logic [falc_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface falc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [falc_pkg::LINE_OUT_W-1:0] line;
    logic [falc_pkg::CNT_W-1:0]      hit_total;
    logic [falc_pkg::CNT_W-1:0]      miss_total;

    modport source (output valid, output hit, output line, output hit_total,
                    output miss_total, input ready);
    modport sink   (input valid, input hit, input line, input hit_total,
                    input miss_total, output ready);
endinterface

`default_nettype wire

[src/falc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module falc_ctrl #(
    parameter int LEVELS = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire falc_pkg::t_status i_status,
    output falc_pkg::t_cmd         o_cmd
);

    localparam int LVL_W = $clog2(LEVELS + 1);

    falc_pkg::t_state r_state, n_state;
    logic [LVL_W-1:0] r_level, n_level;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            falc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = falc_pkg::S_LOOKUP;
                end
            end
            falc_pkg::S_LOOKUP: begin
                n_state = i_status.resolved ? falc_pkg::S_UPDATE : falc_pkg::S_SEARCH;
            end
            falc_pkg::S_SEARCH: begin
                if (r_level == LVL_W'(LEVELS - 1)) begin
                    n_state = falc_pkg::S_UPDATE;
                end
            end
            falc_pkg::S_UPDATE: begin
                if (w_slot_free) begin
                    n_state = i_in_valid ? falc_pkg::S_LOOKUP : falc_pkg::S_IDLE;
                end
            end
            default: n_state = falc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            falc_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            falc_pkg::S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            falc_pkg::S_SEARCH: begin
                o_cmd.reduce = 1'b1;
            end
            falc_pkg::S_UPDATE: begin
                o_cmd.commit = w_slot_free;
                o_in_ready   = w_slot_free;
                o_cmd.accept = w_slot_free && i_in_valid;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_level = r_level;
        if (r_state == falc_pkg::S_LOOKUP) begin
            n_level = '0;
        end else if (r_state == falc_pkg::S_SEARCH) begin
            n_level = r_level + LVL_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= falc_pkg::S_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == falc_pkg::S_LOOKUP || r_state == falc_pkg::S_SEARCH) |-> !o_in_ready)
        else $error("input taken while a lookup is in progress");

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == falc_pkg::S_LOOKUP)
        else $error("accepted item did not start a lookup");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed item not presented");

    a_search_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == falc_pkg::S_SEARCH |-> r_level < LVL_W'(LEVELS))
        else $error("victim search ran past the last level");

endmodule

`default_nettype wire

[src/falc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module falc_dp #(
    parameter int NUM_LINES  = falc_pkg::NUM_LINES_DEF,
    parameter int LINE_BYTES = falc_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS  = falc_pkg::ADDR_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [falc_pkg::ADDR_W-1:0]     i_address,
    input  wire falc_pkg::t_cmd                  i_cmd,
    output falc_pkg::t_status                    o_status,
    output logic                                 o_hit,
    output logic [falc_pkg::LINE_OUT_W-1:0]      o_line,
    output logic [falc_pkg::CNT_W-1:0]           o_hit_total,
    output logic [falc_pkg::CNT_W-1:0]           o_miss_total
);

    localparam int OFF_W  = $clog2(LINE_BYTES + 1) - 1;
    localparam int TAG_W  = ADDR_BITS - OFF_W;
    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int PAD    = 1 << LINE_W;
    localparam int SW     = falc_pkg::STAMP_W;

    logic [ADDR_BITS-1:0] w_addr_ext;

    generate
        if (ADDR_BITS > falc_pkg::ADDR_W) begin : g_addr_wide
            assign w_addr_ext = {{(ADDR_BITS - falc_pkg::ADDR_W){1'b0}}, i_address};
        end else if (ADDR_BITS == falc_pkg::ADDR_W) begin : g_addr_same
            assign w_addr_ext = i_address;
        end else begin : g_addr_narrow
            assign w_addr_ext = i_address[ADDR_BITS-1:0];
        end
    endgenerate

    logic [TAG_W-1:0]     r_tag;
    logic [TAG_W-1:0]     r_line_tag   [NUM_LINES];
    logic [SW-1:0]        r_line_stamp [NUM_LINES];
    logic [NUM_LINES-1:0] r_line_valid;

    logic [NUM_LINES-1:0] w_match;
    logic                 w_any_match;
    logic                 w_any_free;
    logic [LINE_W-1:0]    w_match_idx;
    logic [LINE_W-1:0]    w_free_idx;

    logic                 r_hit;
    logic                 r_free;
    logic [LINE_W-1:0]    r_hit_idx;
    logic [LINE_W-1:0]    r_free_idx;

    logic [LINE_W-1:0]    r_cand_idx   [PAD];
    logic [SW-1:0]        r_cand_stamp [PAD];
    logic [PAD-1:0]       r_cand_ok;

    logic [SW-1:0]             r_clock;
    logic [SW-1:0]             w_stamp_new;
    logic [LINE_W-1:0]         w_victim;
    logic [falc_pkg::CNT_W-1:0] r_hit_count;
    logic [falc_pkg::CNT_W-1:0] r_miss_count;
    logic                      r_out_hit;
    logic [LINE_W-1:0]         r_out_idx;

    // parallel tag compare with lowest index first
    always_comb begin
        w_match_idx = '0;
        w_free_idx  = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            w_match[i] = r_line_valid[i] && (r_line_tag[i] == r_tag);
        end
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_match_idx = LINE_W'(i);
            end
            if (!r_line_valid[i]) begin
                w_free_idx = LINE_W'(i);
            end
        end
        w_any_match = |w_match;
        w_any_free  = ~&r_line_valid;
    end

    assign o_status.resolved = w_any_match || w_any_free;

    assign w_stamp_new = r_clock + SW'(1);
    assign w_victim    = r_hit ? r_hit_idx : (r_free ? r_free_idx : r_cand_idx[0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tag <= w_addr_ext[ADDR_BITS-1:OFF_W];
        end
        if (i_cmd.lookup) begin
            r_hit      <= w_any_match;
            r_free     <= w_any_free;
            r_hit_idx  <= w_match_idx;
            r_free_idx <= w_free_idx;
            for (int j = 0; j < PAD; j++) begin
                r_cand_idx[j]   <= LINE_W'(j);
                r_cand_stamp[j] <= (j < NUM_LINES) ? r_line_stamp[j] : '0;
            end
        end
        // one tournament level per cycle, lower half keeps the winners
        if (i_cmd.reduce) begin
            for (int j = 0; j < PAD / 2; j++) begin
                if (!r_cand_ok[2*j+1] || (r_cand_stamp[2*j] <= r_cand_stamp[2*j+1])) begin
                    r_cand_idx[j]   <= r_cand_idx[2*j];
                    r_cand_stamp[j] <= r_cand_stamp[2*j];
                end else begin
                    r_cand_idx[j]   <= r_cand_idx[2*j+1];
                    r_cand_stamp[j] <= r_cand_stamp[2*j+1];
                end
            end
        end
        if (i_cmd.commit) begin
            r_line_tag[w_victim]   <= r_tag;
            r_line_stamp[w_victim] <= w_stamp_new;
            r_out_hit              <= r_hit;
            r_out_idx              <= w_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_ok <= '0;
        end else if (i_cmd.lookup) begin
            for (int j = 0; j < PAD; j++) begin
                r_cand_ok[j] <= (j < NUM_LINES);
            end
        end else if (i_cmd.reduce) begin
            for (int j = 0; j < PAD / 2; j++) begin
                r_cand_ok[j] <= r_cand_ok[2*j] || r_cand_ok[2*j+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= '0;
            r_clock      <= '0;
            r_hit_count  <= '0;
            r_miss_count <= '0;
        end else if (i_cmd.commit) begin
            r_line_valid[w_victim] <= 1'b1;
            r_clock                <= w_stamp_new;
            if (r_hit) begin
                if (r_hit_count != falc_pkg::CNT_MAX) begin
                    r_hit_count <= r_hit_count + falc_pkg::CNT_W'(1);
                end
            end else if (r_miss_count != falc_pkg::CNT_MAX) begin
                r_miss_count <= r_miss_count + falc_pkg::CNT_W'(1);
            end
        end
    end

    generate
        if (LINE_W >= falc_pkg::LINE_OUT_W) begin : g_line_cut
            assign o_line = r_out_idx[falc_pkg::LINE_OUT_W-1:0];
        end else begin : g_line_ext
            assign o_line = {{(falc_pkg::LINE_OUT_W - LINE_W){1'b0}}, r_out_idx};
        end
    endgenerate

    assign o_hit        = r_out_hit;
    assign o_hit_total  = r_hit_count;
    assign o_miss_total = r_miss_count;

endmodule

`default_nettype wire

[src/fully_assoc_lru_cache_tags.sv]
`timescale 1ns / 1ps
`default_nettype none

// Tag store of a fully associative cache with least recently used replacement.
// Each item is a byte address; the line offset is dropped and the remaining tag
// is compared against every line in parallel. A hit, or a miss that finds a free
// line, goes from the lookup state straight to the update state. A miss with
// every line valid first runs a tournament over the line stamps in the search
// state, one level per cycle, to find the least recently used line. Stamps come
// from a 32-bit access counter, so recency is exact within 2^32 accesses. Hit and
// miss totals saturate at all ones. A finished result waits in an output register,
// and the next item is taken while it waits.
module fully_assoc_lru_cache_tags #(
    parameter int NUM_LINES  = falc_pkg::NUM_LINES_DEF,
    parameter int LINE_BYTES = falc_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS  = falc_pkg::ADDR_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    falc_req_if.sink     i_in,
    falc_rsp_if.source   o_out
);

    falc_pkg::t_cmd    w_cmd;
    falc_pkg::t_status w_status;

    falc_ctrl #(
        .LEVELS ($clog2(NUM_LINES))
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    falc_dp #(
        .NUM_LINES  (NUM_LINES),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_address    (i_in.address),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_hit        (o_out.hit),
        .o_line       (o_out.line),
        .o_hit_total  (o_out.hit_total),
        .o_miss_total (o_out.miss_total)
    );

endmodule

`default_nettype wire
